// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by text_console_writer.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 8;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [6:0]  col;
        logic [4:0]  row;
    } t_req;

    typedef struct packed {
        logic [15:0] cell_word;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic        scrolled;
        logic        status;
    } t_rsp;

    // commands from the sequencer to the cursor unit
    typedef struct packed {
        logic put;
        logic home;
        logic set;
    } t_cur_ctl;

    // what a put would do at the current cursor
    typedef struct packed {
        logic write;
        logic scroll;
    } t_cur_sts;

endpackage

// ===== rtl/core/tcw_chan_if.sv =====
interface tcw_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/text_console_writer.sv =====
// channel  | dir | payload | accepted when
// i_req    | in  | t_req   | valid and ready high at a rising edge
// o_rsp    | out | t_rsp   | valid and ready high at a rising edge
//
// put, set cursor and read: the word is taken, then the result is loaded.
// a put that scrolls then walks the store through one memory port pair: S_COPY moves
//   each row up by one, S_FILL blanks the bottom row, then the result is loaded.
// clear writes every cell once after the word is taken, then the result is loaded.
// after reset the store is blanked, and no word is taken until that is done.
// a stalled result holds in the output register; the next word may be taken, but its
// result waits until the register is free.
`include "assert_macros.svh"

module text_console_writer #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_chan_if.sink    i_req,
    tcw_chan_if.source  o_rsp
);
    import tcw_pkg::*;

    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int CELLS  = COLUMNS * ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int COPY_N = (ROWS - 1) * COLUMNS;

    localparam logic [7:0]    COL_LIM  = 8'(COLUMNS);
    localparam logic [5:0]    ROW_LIM  = 6'(ROWS);
    localparam logic [AW-1:0] LAST     = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END = AW'(COPY_N);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_COPY,
        S_RESP
    } t_state;

    t_state        r_state;
    logic          r_boot;
    logic [AW-1:0] r_cnt;
    logic          r_pend;
    logic [AW-1:0] r_wa;
    t_opcode       r_op;
    logic          r_scroll;
    logic          r_status;
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    logic          w_acc;
    logic          w_in_range;
    logic          w_range_op;
    logic          w_rsp_load;
    logic [CW-1:0] w_cur_col;
    logic [RW-1:0] w_cur_row;
    t_cur_ctl      w_cur_ctl;
    t_cur_sts      w_cur_sts;
    logic [CW-1:0] w_acol;
    logic [RW-1:0] w_arow;
    logic [AW-1:0] w_addr;
    logic          w_copy_rd;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && (r_state == S_IDLE);
    assign w_in_range  = ({1'b0, i_req.payload.col} < COL_LIM)
                      && ({1'b0, i_req.payload.row} < ROW_LIM);
    assign w_range_op  = (i_req.payload.opcode == OP_SET) || (i_req.payload.opcode == OP_READ);
    assign w_rsp_load  = (r_state == S_RESP) && (!r_rsp_valid || o_rsp.ready);

    assign w_cur_ctl.put  = w_acc && (i_req.payload.opcode == OP_PUT);
    assign w_cur_ctl.home = w_acc && (i_req.payload.opcode == OP_CLEAR);
    assign w_cur_ctl.set  = w_acc && (i_req.payload.opcode == OP_SET) && w_in_range;

    tcw_cursor #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_cur_ctl),
        .i_ch      (i_req.payload.char_code),
        .i_set_col (i_req.payload.col[CW-1:0]),
        .i_set_row (i_req.payload.row[RW-1:0]),
        .o_col     (w_cur_col),
        .o_row     (w_cur_row),
        .o_sts     (w_cur_sts)
    );

    // shared cell address: read position for a read, else the cursor
    always_comb begin
        if (i_req.payload.opcode == OP_READ) begin
            w_acol = i_req.payload.col[CW-1:0];
            w_arow = i_req.payload.row[RW-1:0];
        end else begin
            w_acol = w_cur_col;
            w_arow = w_cur_row;
        end
    end

    assign w_addr    = AW'(AW'(w_arow) * AW'(COLUMNS)) + AW'(w_acol);
    assign w_copy_rd = (r_cnt != COPY_END);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_addr;
        w_wdata = {i_req.payload.attribute, i_req.payload.char_code};
        w_re    = 1'b0;
        w_raddr = w_addr;
        case (r_state)
            S_IDLE: begin
                w_we = w_cur_ctl.put && w_cur_sts.write;
                w_re = w_acc && (i_req.payload.opcode == OP_READ) && w_in_range;
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = BLANK_CELL;
            end
            S_COPY: begin
                // read one row ahead, write the word read last cycle
                w_we    = r_pend;
                w_waddr = r_wa;
                w_wdata = w_rdata;
                w_re    = w_copy_rd;
                w_raddr = r_cnt + AW'(COLUMNS);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    tcw_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_boot      <= 1'b1;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_op        <= OP_PUT;
            r_scroll    <= 1'b0;
            r_status    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op     <= i_req.payload.opcode;
                        r_scroll <= (i_req.payload.opcode == OP_PUT) && w_cur_sts.scroll;
                        r_status <= w_range_op && !w_in_range;
                        r_cnt    <= '0;
                        r_pend   <= 1'b0;
                        case (i_req.payload.opcode)
                            OP_PUT: begin
                                r_state <= w_cur_sts.scroll ? S_COPY : S_RESP;
                            end
                            OP_CLEAR: begin
                                r_state <= S_FILL;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_COPY: begin
                    r_pend <= w_copy_rd;
                    r_wa   <= r_cnt;
                    if (w_copy_rd) begin
                        r_cnt <= r_cnt + AW'(1);
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_cnt == LAST) begin
                        r_boot  <= 1'b0;
                        r_state <= r_boot ? S_IDLE : S_RESP;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_RESP: begin
                    if (w_rsp_load) begin
                        r_rsp.cell_word    <= (r_op == OP_READ && !r_status) ? w_rdata : '0;
                        r_rsp.cursor_col   <= 7'(w_cur_col);
                        r_rsp.cursor_row   <= 5'(w_cur_row);
                        r_rsp.scrolled     <= r_scroll;
                        r_rsp.status       <= r_status;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    `TCW_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, 1'b1,
        (w_cur_col < CW'(COLUMNS - 1) || w_cur_col == CW'(COLUMNS - 1))
        && (w_cur_row < RW'(ROWS - 1) || w_cur_row == RW'(ROWS - 1)),
        "cursor left the screen")
    `TCW_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, w_acc, !i_req.ready,
        "word taken while the previous one is still at work")
    `TCW_ASSERT_IMP(a_copy_bound, i_clk, i_rst_n, (r_state == S_COPY) && r_pend,
        r_wa < COPY_END, "scroll copy wrote into the bottom row")
    `TCW_ASSERT_IMP(a_scroll_on_put, i_clk, i_rst_n, (r_state == S_RESP) && r_scroll,
        r_op == OP_PUT, "scroll flagged for an operation other than put")
    `TCW_ASSERT_IMP(a_status_source, i_clk, i_rst_n, (r_state == S_RESP) && r_status,
        (r_op == OP_SET) || (r_op == OP_READ), "range error flagged for put or clear")
endmodule

// ===== rtl/core/tcw_store.sv =====
module tcw_store #(
    parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/tcw_cursor.sv =====
module tcw_cursor #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcw_pkg::DEF_TAB_STOP
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcw_pkg::t_cur_ctl            i_ctl,
    input  logic [7:0]                   i_ch,
    input  logic [$clog2(COLUMNS)-1:0]   i_set_col,
    input  logic [$clog2(ROWS)-1:0]      i_set_row,
    output logic [$clog2(COLUMNS)-1:0]   o_col,
    output logic [$clog2(ROWS)-1:0]      o_row,
    output tcw_pkg::t_cur_sts            o_sts
);
    import tcw_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int XW = $clog2(COLUMNS + TAB_STOP);
    localparam int YW = $clog2(ROWS + 1);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [XW-1:0] w_tab [2**CW];
    logic [XW-1:0] w_c;
    logic [YW-1:0] w_r;
    logic          w_write;
    logic          w_scroll;

    // next tab stop for every column
    for (genvar g = 0; g < 2**CW; g++) begin : g_tab
        assign w_tab[g] = XW'(g + TAB_STOP - g % TAB_STOP);
    end

    always_comb begin
        w_c     = XW'(r_col);
        w_r     = YW'(r_row);
        w_write = 1'b0;
        case (i_ch)
            CH_LF: begin
                w_c = '0;
                w_r = w_r + YW'(1);
            end
            CH_TAB: begin
                w_c = w_tab[r_col];
            end
            CH_CR: begin
                w_c = '0;
            end
            default: begin
                if (!i_ch[7] && i_ch >= CH_SPACE) begin
                    w_write = 1'b1;
                    w_c     = w_c + XW'(1);
                end
            end
        endcase
        // wrap past the last column
        if (w_c >= XW'(COLUMNS)) begin
            w_c = '0;
            w_r = w_r + YW'(1);
        end
        w_scroll = (w_r >= YW'(ROWS));
        if (w_scroll) begin
            w_r = YW'(ROWS - 1);
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_ctl.home) begin
            n_col = '0;
            n_row = '0;
        end else if (i_ctl.set) begin
            n_col = i_set_col;
            n_row = i_set_row;
        end else if (i_ctl.put) begin
            n_col = w_c[CW-1:0];
            n_row = w_r[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col        = r_col;
    assign o_row        = r_row;
    assign o_sts.write  = w_write;
    assign o_sts.scroll = w_scroll;
endmodule
